### hdl/vvt_pkg.sv
// Shared types and constants for the version vector table.
// Holds the item, result and entry structs and the opcode and status codes.
// No dependencies.
package vvt_pkg;

  localparam int MaxEntries = 16;
  localparam int AddrW      = 4;
  localparam int CntW       = 5;
  localparam int IdW        = 64;
  localparam int ValW       = 63;

  localparam logic [2:0] OpClear    = 3'd0;
  localparam logic [2:0] OpLoad     = 3'd1;
  localparam logic [2:0] OpUpdate   = 3'd2;
  localparam logic [2:0] OpBest     = 3'd3;
  localparam logic [2:0] OpContains = 3'd4;
  localparam logic [2:0] OpCompare  = 3'd5;
  localparam logic [2:0] OpRead     = 3'd6;
  localparam logic [2:0] OpNop      = 3'd7;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [IdW-1:0]  node_id;
    logic [ValW-1:0] value;
    logic [3:0]      index;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdW-1:0]  entry_id;
    logic [ValW-1:0] entry_value;
    logic            answer;
    logic [4:0]      entry_count;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [ValW-1:0] value;
  } entry_t;

endpackage

### hdl/vvt_mem.sv
// Entry store of the version vector table: one write port, one registered read port.
// Depends on vvt_pkg.
module vvt_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [vvt_pkg::AddrW-1:0] waddr,
  input  vvt_pkg::entry_t           wdata,
  input  logic [vvt_pkg::AddrW-1:0] raddr,
  output vvt_pkg::entry_t           rdata
);

  vvt_pkg::entry_t mem [vvt_pkg::MaxEntries];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/version_vector_table.sv
// Version vector table: top level with the operation sequencer.
// Depends on vvt_pkg and vvt_mem.
//
// One item is taken when start is high and busy is low. Clear, a non-final load, read out
// of range, best with no mark and opcode 7 leave busy low, so another item can be taken at
// the next edge; their result, if any, is shown in the cycle right after acceptance. Best,
// read and compare hold busy high through one more state, SRd or SCmp, and show the result
// in the cycle after it. Update, contains and a final load scan the stored entries through
// the single read port of the entry memory, one entry per cycle, in state SScan and then
// SFin, with SBrd first for an update while a best mark exists; update and contains stop
// early on a matching id. Busy drops in the cycle that shows the result. Each result is
// shown for one cycle with done high and must be taken then; the block never waits on the
// receiver. Opcode 7 is accepted and answers nothing.
module version_vector_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  vvt_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done,
  output vvt_pkg::rsp_t   rsp
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SBrd  = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SFin  = 3'd3;
  localparam logic [2:0] SRd   = 3'd4;
  localparam logic [2:0] SCmp  = 3'd5;

  localparam logic [vvt_pkg::CntW-1:0] MaxCnt = vvt_pkg::CntW'(vvt_pkg::MaxEntries);
  localparam logic [vvt_pkg::ValW-1:0] ValMax = '1;

  logic [2:0]                  state;
  vvt_pkg::cmd_t               item;
  logic [vvt_pkg::CntW-1:0]    count;
  logic                        best_valid;
  logic [vvt_pkg::AddrW-1:0]   best_slot;
  logic [vvt_pkg::CntW-1:0]    cmp_pos;
  logic                        cmp_ok;
  logic                        cmp_in;
  logic [vvt_pkg::CntW-1:0]    ptr;
  logic                        pend;
  logic [vvt_pkg::AddrW-1:0]   pidx;
  logic                        found;
  logic [vvt_pkg::AddrW-1:0]   fslot;
  logic [vvt_pkg::ValW-1:0]    fval;
  logic                        sb_valid;
  logic [vvt_pkg::AddrW-1:0]   sb_slot;
  logic [vvt_pkg::ValW-1:0]    sb_val;
  logic [vvt_pkg::ValW-1:0]    upd_val;
  logic [1:0]                  st;

  logic                        accept;
  logic                        we;
  logic [vvt_pkg::AddrW-1:0]   waddr;
  vvt_pkg::entry_t             wdata;
  logic [vvt_pkg::AddrW-1:0]   raddr;
  vvt_pkg::entry_t             rdata;
  logic                        hit;
  logic [vvt_pkg::ValW:0]      inc;
  logic [vvt_pkg::ValW-1:0]    nb;
  logic                        cmp_ok_next;
  logic [vvt_pkg::CntW-1:0]    cmp_pos_next;

  assign accept = start && !busy;
  assign busy   = (state != SIdle);

  vvt_mem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    raddr = '0;
    unique case (state)
      SIdle: begin
        case (cmd.opcode) inside
          vvt_pkg::OpUpdate, vvt_pkg::OpBest: raddr = best_slot;
          vvt_pkg::OpRead:                    raddr = cmd.index;
          vvt_pkg::OpCompare:                 raddr = cmp_pos[vvt_pkg::AddrW-1:0];
          default:                            raddr = '0;
        endcase
      end
      SScan:   raddr = ptr[vvt_pkg::AddrW-1:0];
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[vvt_pkg::AddrW-1:0];
    wdata = '{id: item.node_id, value: upd_val};
    if (state == SIdle && accept && cmd.opcode == vvt_pkg::OpLoad && count < MaxCnt) begin
      we    = 1'b1;
      wdata = '{id: cmd.node_id, value: cmd.value};
    end else if (state == SFin && item.opcode == vvt_pkg::OpUpdate) begin
      if (found) begin
        we    = 1'b1;
        waddr = fslot;
      end else if (count < MaxCnt) begin
        we = 1'b1;
      end
    end
  end

  assign hit = pend && (rdata.id == item.node_id);
  assign inc = {1'b0, rdata.value} + 64'd1;
  assign nb  = (rdata.value == ValMax) ? ValMax : inc[vvt_pkg::ValW-1:0];

  assign cmp_ok_next  = cmp_ok && cmp_in && (rdata.id == item.node_id) &&
                        (rdata.value == item.value);
  assign cmp_pos_next = (cmp_pos <= MaxCnt) ? cmp_pos + 1'b1 : cmp_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SIdle;
      done       <= 1'b0;
      count      <= '0;
      best_valid <= 1'b0;
      best_slot  <= '0;
      cmp_pos    <= '0;
      cmp_ok     <= 1'b1;
      pend       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        SIdle: begin
          if (accept) begin
            item        <= cmd;
            ptr         <= '0;
            pend        <= 1'b0;
            found       <= 1'b0;
            sb_valid    <= 1'b0;
            st          <= vvt_pkg::StOk;
            rsp         <= '0;
            rsp.entry_count <= count;
            case (cmd.opcode)
              vvt_pkg::OpClear: begin
                count           <= '0;
                best_valid      <= 1'b0;
                best_slot       <= '0;
                cmp_pos         <= '0;
                cmp_ok          <= 1'b1;
                rsp.entry_count <= '0;
                done            <= 1'b1;
              end
              vvt_pkg::OpLoad: begin
                if (count < MaxCnt) begin
                  count           <= count + 1'b1;
                  rsp.entry_count <= count + 1'b1;
                end else begin
                  st         <= vvt_pkg::StFull;
                  rsp.status <= vvt_pkg::StFull;
                end
                if (cmd.last) begin
                  state <= SScan;
                end else begin
                  done <= 1'b1;
                end
              end
              vvt_pkg::OpUpdate: begin
                if (best_valid) begin
                  state <= SBrd;
                end else begin
                  upd_val <= cmd.value;
                  state   <= SScan;
                end
              end
              vvt_pkg::OpContains: state <= SScan;
              vvt_pkg::OpBest: begin
                if (best_valid) begin
                  state <= SRd;
                end else begin
                  done <= 1'b1;
                end
              end
              vvt_pkg::OpRead: begin
                if (vvt_pkg::CntW'(cmd.index) < count) begin
                  state <= SRd;
                end else begin
                  rsp.status <= vvt_pkg::StRange;
                  done       <= 1'b1;
                end
              end
              vvt_pkg::OpCompare: begin
                cmp_in <= (cmp_pos < count);
                state  <= SCmp;
              end
              default: state <= SIdle;
            endcase
          end
        end
        SBrd: begin
          upd_val <= (nb > item.value) ? nb : item.value;
          state   <= SScan;
        end
        SScan: begin
          if (item.opcode == vvt_pkg::OpLoad) begin
            if (pend && (!sb_valid || rdata.value > sb_val)) begin
              sb_valid <= 1'b1;
              sb_slot  <= pidx;
              sb_val   <= rdata.value;
            end
          end else if (hit && !found) begin
            found <= 1'b1;
            fslot <= pidx;
            fval  <= rdata.value;
          end
          if ((hit && item.opcode != vvt_pkg::OpLoad) || ptr >= count) begin
            pend  <= 1'b0;
            state <= SFin;
          end else begin
            pend <= 1'b1;
            pidx <= ptr[vvt_pkg::AddrW-1:0];
            ptr  <= ptr + 1'b1;
          end
        end
        SFin: begin
          done  <= 1'b1;
          state <= SIdle;
          case (item.opcode)
            vvt_pkg::OpLoad: begin
              best_valid <= sb_valid;
              best_slot  <= sb_valid ? sb_slot : '0;
            end
            vvt_pkg::OpUpdate: begin
              if (found || count < MaxCnt) begin
                best_valid      <= 1'b1;
                best_slot       <= found ? fslot : count[vvt_pkg::AddrW-1:0];
                rsp.entry_id    <= item.node_id;
                rsp.entry_value <= upd_val;
                if (!found) begin
                  count           <= count + 1'b1;
                  rsp.entry_count <= count + 1'b1;
                end
              end else begin
                rsp.status <= vvt_pkg::StFull;
              end
            end
            vvt_pkg::OpContains: rsp.answer <= found && (fval >= item.value);
            default: rsp.status <= st;
          endcase
        end
        SRd: begin
          rsp.entry_id    <= rdata.id;
          rsp.entry_value <= rdata.value;
          done            <= 1'b1;
          state           <= SIdle;
        end
        SCmp: begin
          if (item.last) begin
            rsp.answer <= cmp_ok_next && (cmp_pos_next == count);
            cmp_pos    <= '0;
            cmp_ok     <= 1'b1;
          end else begin
            rsp.answer <= cmp_ok_next;
            cmp_pos    <= cmp_pos_next;
            cmp_ok     <= cmp_ok_next;
          end
          done  <= 1'b1;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench for version_vector_table: directed table of items, then random traffic.
// Each result is checked field by field against a behavioral model of the table.
// Depends on vvt_pkg and the version_vector_table RTL.
module tb;

  localparam logic [vvt_pkg::ValW-1:0] ValMax = {vvt_pkg::ValW{1'b1}};

  logic           clk;
  logic           rst;
  logic           start;
  vvt_pkg::cmd_t  cmd;
  logic           busy;
  logic           done;
  vvt_pkg::rsp_t  rsp;

  version_vector_table u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  logic [vvt_pkg::IdW-1:0]  tbl_id  [vvt_pkg::MaxEntries];
  logic [vvt_pkg::ValW-1:0] tbl_val [vvt_pkg::MaxEntries];
  int              tbl_count;
  bit              best_marked;
  int              best_idx;
  int              cmp_pos;
  bit              cmp_match;

  vvt_pkg::rsp_t pending_rsp[$];
  int   errors;
  int   idle_pct;
  int   got_count;
  int   sent;

  typedef struct {
    vvt_pkg::cmd_t c;
    bit            has_exp;
    vvt_pkg::rsp_t e;
  } row_t;

  row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("version_vector_table test failed");
    $finish;
  end

  function automatic int lookup_id(logic [vvt_pkg::IdW-1:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void pick_best();
    best_marked = 1'b0;
    best_idx = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (!best_marked || tbl_val[i] > tbl_val[best_idx]) begin
        best_marked = 1'b1;
        best_idx = i;
      end
    end
  endfunction

  function automatic bit table_step(vvt_pkg::cmd_t c, output vvt_pkg::rsp_t r);
    int s;
    logic [vvt_pkg::ValW-1:0] v;
    r = '0;
    case (c.opcode)
      vvt_pkg::OpClear: begin
        tbl_count = 0;
        best_marked = 1'b0;
        best_idx = 0;
        cmp_pos = 0;
        cmp_match = 1'b1;
      end
      vvt_pkg::OpLoad: begin
        if (tbl_count < vvt_pkg::MaxEntries) begin
          tbl_id[tbl_count] = c.node_id;
          tbl_val[tbl_count] = c.value;
          tbl_count++;
        end else begin
          r.status = vvt_pkg::StFull;
        end
        if (c.last) pick_best();
      end
      vvt_pkg::OpUpdate: begin
        v = c.value;
        if (best_marked) begin
          if (tbl_val[best_idx] == ValMax) begin
            v = ValMax;
          end else if (tbl_val[best_idx] + 1 > v) begin
            v = tbl_val[best_idx] + 1;
          end
        end
        s = lookup_id(c.node_id);
        if (s < 0 && tbl_count < vvt_pkg::MaxEntries) begin
          s = tbl_count;
          tbl_id[s] = c.node_id;
          tbl_count++;
        end
        if (s >= 0) begin
          tbl_val[s] = v;
          best_marked = 1'b1;
          best_idx = s;
          r.entry_id = c.node_id;
          r.entry_value = v;
        end else begin
          r.status = vvt_pkg::StFull;
        end
      end
      vvt_pkg::OpBest: begin
        if (best_marked) begin
          r.entry_id = tbl_id[best_idx];
          r.entry_value = tbl_val[best_idx];
        end
      end
      vvt_pkg::OpContains: begin
        s = lookup_id(c.node_id);
        r.answer = (s >= 0) && (tbl_val[s] >= c.value);
      end
      vvt_pkg::OpCompare: begin
        if (cmp_pos < tbl_count) begin
          if (tbl_id[cmp_pos] != c.node_id || tbl_val[cmp_pos] != c.value)
            cmp_match = 1'b0;
        end else begin
          cmp_match = 1'b0;
        end
        if (cmp_pos <= vvt_pkg::MaxEntries) cmp_pos++;
        if (c.last) begin
          r.answer = cmp_match && (cmp_pos == tbl_count);
          cmp_pos = 0;
          cmp_match = 1'b1;
        end else begin
          r.answer = cmp_match;
        end
      end
      vvt_pkg::OpRead: begin
        if (c.index < tbl_count) begin
          r.entry_id = tbl_id[c.index];
          r.entry_value = tbl_val[c.index];
        end else begin
          r.status = vvt_pkg::StRange;
        end
      end
      default: return 1'b0;
    endcase
    r.entry_count = tbl_count[4:0];
    return 1'b1;
  endfunction

  function automatic vvt_pkg::cmd_t mk(logic [2:0] op, logic [vvt_pkg::IdW-1:0] id,
                                       logic [vvt_pkg::ValW-1:0] v, logic [3:0] ix,
                                       logic lst);
    vvt_pkg::cmd_t c;
    c.opcode = op;
    c.node_id = id;
    c.value = v;
    c.index = ix;
    c.last = lst;
    return c;
  endfunction

  function automatic vvt_pkg::rsp_t mkr(logic [1:0] st, logic [vvt_pkg::IdW-1:0] id,
                                        logic [vvt_pkg::ValW-1:0] v, logic a,
                                        logic [4:0] n);
    vvt_pkg::rsp_t r;
    r.status = st;
    r.entry_id = id;
    r.entry_value = v;
    r.answer = a;
    r.entry_count = n;
    return r;
  endfunction

  function automatic void add_row(vvt_pkg::cmd_t c, bit he, vvt_pkg::rsp_t e);
    row_t rw;
    rw.c = c;
    rw.has_exp = he;
    rw.e = e;
    rows.push_back(rw);
  endfunction

  always @(posedge clk) begin
    vvt_pkg::rsp_t e;
    if (!rst && done) begin
      got_count++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
        if (rsp.entry_id !== e.entry_id)
          $display("%0t: entry_id exp %h got %h", $time, e.entry_id, rsp.entry_id);
        if (rsp.entry_value !== e.entry_value)
          $display("%0t: entry_value exp %h got %h", $time, e.entry_value, rsp.entry_value);
        if (rsp.answer !== e.answer)
          $display("%0t: answer exp %0d got %0d", $time, e.answer, rsp.answer);
        if (rsp.entry_count !== e.entry_count)
          $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count, rsp.entry_count);
        if (rsp !== e) errors++;
      end
    end
  end

  task automatic send_item(vvt_pkg::cmd_t c, bit he, vvt_pkg::rsp_t e);
    vvt_pkg::rsp_t p;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sent++;
    if (table_step(c, p)) begin
      if (he && p !== e) begin
        $display("%0t: table row exp %h model %h", $time, e, p);
        errors++;
      end
      pending_rsp.push_back(p);
    end
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (pending_rsp.size() != 0 && n < 10000) begin
      @(posedge clk);
      n++;
    end
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [vvt_pkg::IdW-1:0] rand_id(bit wide);
    if (wide) return {$urandom, $urandom};
    return vvt_pkg::IdW'($urandom_range(5));
  endfunction

  function automatic logic [vvt_pkg::ValW-1:0] rand_val();
    case ($urandom_range(3))
      0: return vvt_pkg::ValW'($urandom_range(20));
      1: return ValMax - vvt_pkg::ValW'($urandom_range(2));
      default: return vvt_pkg::ValW'({$urandom, $urandom} >> 1);
    endcase
  endfunction

  task automatic random_burst();
    int k;
    int n;
    bit wide;
    vvt_pkg::cmd_t c;
    logic [vvt_pkg::IdW-1:0]  ids [vvt_pkg::MaxEntries];
    logic [vvt_pkg::ValW-1:0] vals[vvt_pkg::MaxEntries];
    case ($urandom_range(5))
      0: begin
        n = $urandom_range(1, 18);
        for (k = 0; k < n; k++) begin
          wide = 1'($urandom_range(1));
          send_item(mk(vvt_pkg::OpLoad, rand_id(wide), rand_val(), 4'($urandom),
                       k == n - 1), 0, '0);
        end
      end
      1: begin
        n = tbl_count;
        for (k = 0; k < n; k++) begin
          ids[k] = tbl_id[k];
          vals[k] = tbl_val[k];
        end
        if ($urandom_range(3) == 0) n = n + $urandom_range(2) - 1;
        if (n < 1) n = 1;
        for (k = 0; k < n; k++) begin
          c = mk(vvt_pkg::OpCompare, k < tbl_count ? ids[k] : rand_id(1),
                 k < tbl_count ? vals[k] : rand_val(), 4'($urandom), k == n - 1);
          if ($urandom_range(7) == 0) c.value[$urandom_range(vvt_pkg::ValW - 1)] ^= 1'b1;
          send_item(c, 0, '0);
        end
      end
      default: begin
        c = mk(3'($urandom_range(7)), rand_id($urandom_range(3) == 0), rand_val(),
               4'($urandom), 1'($urandom));
        if (c.opcode == vvt_pkg::OpClear && $urandom_range(3) != 0)
          c.opcode = vvt_pkg::OpUpdate;
        if (c.opcode == vvt_pkg::OpContains && tbl_count > 0 && $urandom_range(1)) begin
          k = $urandom_range(tbl_count - 1);
          c.node_id = tbl_id[k];
          c.value = tbl_val[k] + vvt_pkg::ValW'($urandom_range(2)) - 1;
        end
        send_item(c, 0, '0);
      end
    endcase
  endtask

  initial begin
    logic [vvt_pkg::IdW-1:0] all1;
    all1 = '1;
    errors = 0;
    got_count = 0;
    sent = 0;
    idle_pct = 0;
    tbl_count = 0;
    best_marked = 1'b0;
    best_idx = 0;
    cmp_pos = 0;
    cmp_match = 1'b1;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_row(mk(vvt_pkg::OpBest, 0, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 0));
    add_row(mk(vvt_pkg::OpRead, 0, 0, 0, 0), 1, mkr(vvt_pkg::StRange, 0, 0, 0, 0));
    add_row(mk(vvt_pkg::OpLoad, 0, 0, 0, 1), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 1));
    add_row(mk(vvt_pkg::OpBest, 0, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 1));
    add_row(mk(vvt_pkg::OpClear, 0, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 0));
    add_row(mk(vvt_pkg::OpBest, 0, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 0));
    add_row(mk(vvt_pkg::OpUpdate, all1, 5, 0, 0), 1, mkr(vvt_pkg::StOk, all1, 5, 0, 1));
    add_row(mk(vvt_pkg::OpUpdate, 7, ValMax, 0, 0), 1, mkr(vvt_pkg::StOk, 7, ValMax, 0, 2));
    add_row(mk(vvt_pkg::OpUpdate, all1, 0, 0, 0), 1,
            mkr(vvt_pkg::StOk, all1, ValMax, 0, 2));
    add_row(mk(vvt_pkg::OpContains, all1, ValMax, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 1, 2));
    add_row(mk(vvt_pkg::OpContains, 9, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 2));
    add_row(mk(vvt_pkg::OpCompare, all1, ValMax, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 1, 2));
    add_row(mk(vvt_pkg::OpCompare, 7, ValMax, 0, 1), 1, mkr(vvt_pkg::StOk, 0, 0, 1, 2));
    add_row(mk(vvt_pkg::OpCompare, all1, ValMax, 0, 1), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 2));
    add_row(mk(vvt_pkg::OpRead, 0, 0, 15, 0), 1, mkr(vvt_pkg::StRange, 0, 0, 0, 2));
    add_row(mk(vvt_pkg::OpRead, 0, 0, 1, 0), 0, '0);
    add_row(mk(vvt_pkg::OpNop, all1, ValMax, 15, 1), 0, '0);
    add_row(mk(vvt_pkg::OpClear, 0, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      add_row(mk(vvt_pkg::OpLoad, i, i == 3 ? 100 : 1, 0, i == 16), 0, '0);
    add_row(mk(vvt_pkg::OpUpdate, 99, 0, 0, 0), 1, mkr(vvt_pkg::StFull, 0, 0, 0, 16));
    add_row(mk(vvt_pkg::OpBest, 0, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 3, 100, 0, 16));
    add_row(mk(vvt_pkg::OpRead, 0, 0, 15, 0), 1, mkr(vvt_pkg::StOk, 15, 1, 0, 16));
    add_row(mk(vvt_pkg::OpUpdate, 15, 0, 0, 0), 1, mkr(vvt_pkg::StOk, 15, 101, 0, 16));
    add_row(mk(vvt_pkg::OpCompare, 0, 1, 0, 1), 0, '0);

    foreach (rows[i]) send_item(rows[i].c, rows[i].has_exp, rows[i].e);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 7 : (ph == 1) ? 67 : 0;
      while (sent < 283 * (ph + 1)) begin
        random_burst();
        if ($urandom_range(60) == 0) drain();
      end
    end
    drain();

    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("version_vector_table test passed");
    end else begin
      $display("version_vector_table test failed");
    end
    $finish;
  end
endmodule
